FILE: rtl/dlv_pkg.sv
// ----------------------------------------------------------------------------
// dlv_pkg
// Types, constants and helper functions of the delimited record validator.
// ----------------------------------------------------------------------------
package dlv_pkg;

  localparam int unsigned FIELD_COUNT = 6;
  localparam int unsigned IDX_W       = 3;
  localparam int unsigned VAL_W       = 14;
  localparam int unsigned SVAL_W      = VAL_W + 1;
  localparam int unsigned MAC_W       = 17;

  localparam logic [VAL_W-1:0] ACC_SAT = 14'd10000;

  localparam logic [7:0] CH_SEMI  = 8'h3B;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;

  localparam logic [IDX_W-1:0] IDX_YEAR   = 3'd0;
  localparam logic [IDX_W-1:0] IDX_MONTH  = 3'd1;
  localparam logic [IDX_W-1:0] IDX_DAY    = 3'd2;
  localparam logic [IDX_W-1:0] IDX_HOUR   = 3'd3;
  localparam logic [IDX_W-1:0] IDX_MINUTE = 3'd4;
  localparam logic [IDX_W-1:0] IDX_TEMP   = 3'd5;
  localparam logic [IDX_W-1:0] IDX_FULL   = 3'd6;

  typedef enum logic [2:0] {
    PH_BETWEEN = 3'd0,
    PH_LEAD    = 3'd1,
    PH_SIGN    = 3'd2,
    PH_DIGITS  = 3'd3,
    PH_BAD     = 3'd4,
    PH_IGNORE  = 3'd5
  } phase_e;

  typedef logic [VAL_W-1:0]         val_t;
  typedef logic signed [SVAL_W-1:0] sval_t;

  function automatic logic is_ws(input logic [7:0] c);
    return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

  function automatic sval_t range_lo(input logic [IDX_W-1:0] idx);
    sval_t lo;
    unique case (idx)
      IDX_YEAR:   lo = 15'sd1000;
      IDX_MONTH:  lo = 15'sd1;
      IDX_DAY:    lo = 15'sd1;
      IDX_HOUR:   lo = 15'sd0;
      IDX_MINUTE: lo = 15'sd0;
      IDX_TEMP:   lo = -15'sd99;
      default:    lo = 15'sd1;
    endcase
    return lo;
  endfunction

  function automatic sval_t range_hi(input logic [IDX_W-1:0] idx);
    sval_t hi;
    unique case (idx)
      IDX_YEAR:   hi = 15'sd9999;
      IDX_MONTH:  hi = 15'sd12;
      IDX_DAY:    hi = 15'sd31;
      IDX_HOUR:   hi = 15'sd23;
      IDX_MINUTE: hi = 15'sd59;
      IDX_TEMP:   hi = 15'sd99;
      default:    hi = 15'sd0;
    endcase
    return hi;
  endfunction

endpackage

FILE: rtl/dlv_in_if.sv
// ----------------------------------------------------------------------------
// dlv_in_if
// Byte request channel of the delimited record validator.
// ----------------------------------------------------------------------------
interface dlv_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] ch;
  logic       line_end;

  modport source (output valid, output ch, output line_end, input ready);
  modport sink   (input valid, input ch, input line_end, output ready);
endinterface

FILE: rtl/dlv_out_if.sv
// ----------------------------------------------------------------------------
// dlv_out_if
// Record request channel of the delimited record validator.
// ----------------------------------------------------------------------------
interface dlv_out_if;
  logic               valid;
  logic               ready;
  logic               ok;
  logic [13:0]        year;
  logic [3:0]         month;
  logic [4:0]         day;
  logic [4:0]         hour;
  logic [5:0]         minute;
  logic signed [7:0]  temperature;
  logic [23:0]        good_line_count;

  modport source (output valid, output ok, output year, output month, output day,
                  output hour, output minute, output temperature,
                  output good_line_count, input ready);
  modport sink   (input valid, input ok, input year, input month, input day,
                  input hour, input minute, input temperature,
                  input good_line_count, output ready);
endinterface

FILE: rtl/delimited_record_validator.sv
// a line-end request gives its record in the register in the cycle after acceptance
// throughput: one byte request per cycle; input stalls only while a record waits and
//   the output is not ready
// the per-byte parser state updates in the accepting cycle (multiply-by-ten add, range check)
// reset: line state and the good-line counter clear, no record is pending
// ----------------------------------------------------------------------------
// delimited_record_validator
// Splits a byte stream on ';' into six numeric fields, range checks them and
// emits one record per line with the count of earlier good lines.
// ----------------------------------------------------------------------------
module delimited_record_validator
  import dlv_pkg::*;
#(
  parameter int unsigned COUNT_WIDTH = 24
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  dlv_in_if.sink      in_if,
  dlv_out_if.source   out_if
);

  localparam int unsigned OUT_CNT_W = 24;

  phase_e                 phase_q, phase_d;
  logic [IDX_W-1:0]       idx_q, idx_d;
  val_t                   acc_q, acc_d;
  logic                   neg_q, neg_d;
  val_t                   vals_q [FIELD_COUNT];
  val_t                   vals_d [FIELD_COUNT];
  logic                   bad_q, bad_d;
  logic [COUNT_WIDTH-1:0] count_q, count_d;

  logic                   out_valid_q, out_valid_d;
  logic                   ok_q, ok_d;
  val_t                   year_q, year_d;
  logic [3:0]             month_q, month_d;
  logic [4:0]             day_q, day_d;
  logic [4:0]             hour_q, hour_d;
  logic [5:0]             minute_q, minute_d;
  logic [7:0]             temp_q, temp_d;
  logic [OUT_CNT_W-1:0]   glc_q, glc_d;

  logic                   accept;
  logic [31:0]            count_ext;

  assign in_if.ready = !out_valid_q || out_if.ready;
  assign accept      = in_if.valid && in_if.ready;
  assign count_ext   = 32'(count_q);

  always_comb begin
    sval_t            sval;
    logic             tok_ok;
    logic             need_close;
    val_t             vals_c [FIELD_COUNT];
    logic             bad_c;
    logic [IDX_W-1:0] idx_c;
    phase_e           phase_c;
    val_t             end_vals [FIELD_COUNT];
    logic             end_bad;
    logic [IDX_W-1:0] end_idx;
    logic             line_ok;
    phase_e           ph;
    logic [MAC_W-1:0] mac;

    phase_d = phase_q;
    idx_d   = idx_q;
    acc_d   = acc_q;
    neg_d   = neg_q;
    vals_d  = vals_q;
    bad_d   = bad_q;
    count_d = count_q;

    out_valid_d = out_valid_q && !out_if.ready;
    ok_d     = ok_q;
    year_d   = year_q;
    month_d  = month_q;
    day_d    = day_q;
    hour_d   = hour_q;
    minute_d = minute_q;
    temp_d   = temp_q;
    glc_d    = glc_q;

    // token close
    sval   = neg_q ? -$signed({1'b0, acc_q}) : $signed({1'b0, acc_q});
    tok_ok = (phase_q == PH_DIGITS) && (sval >= range_lo(idx_q)) && (sval <= range_hi(idx_q));
    vals_c = vals_q;
    for (int i = 0; i < FIELD_COUNT; i++) begin
      if (tok_ok && (idx_q == IDX_W'(i))) begin
        vals_c[i] = sval[VAL_W-1:0];
      end
    end
    bad_c   = bad_q || !tok_ok;
    idx_c   = idx_q + 1'b1;
    phase_c = (idx_c == IDX_FULL) ? PH_IGNORE : PH_BETWEEN;

    need_close = (phase_q != PH_BETWEEN) && (phase_q != PH_IGNORE);
    end_vals   = need_close ? vals_c : vals_q;
    end_bad    = need_close ? bad_c : bad_q;
    end_idx    = need_close ? idx_c : idx_q;
    line_ok    = !end_bad && (end_idx == IDX_FULL);

    ph  = phase_q;
    mac = '0;

    if (accept) begin
      if (in_if.line_end) begin
        out_valid_d = 1'b1;
        ok_d     = line_ok;
        year_d   = line_ok ? end_vals[IDX_YEAR] : '0;
        month_d  = line_ok ? end_vals[IDX_MONTH][3:0] : '0;
        day_d    = line_ok ? end_vals[IDX_DAY][4:0] : '0;
        hour_d   = line_ok ? end_vals[IDX_HOUR][4:0] : '0;
        minute_d = line_ok ? end_vals[IDX_MINUTE][5:0] : '0;
        temp_d   = line_ok ? end_vals[IDX_TEMP][7:0] : '0;
        glc_d    = count_ext[OUT_CNT_W-1:0];
        if (line_ok && (count_q != '1)) begin
          count_d = count_q + 1'b1;
        end
        phase_d = PH_BETWEEN;
        idx_d   = '0;
        acc_d   = '0;
        neg_d   = 1'b0;
        for (int i = 0; i < FIELD_COUNT; i++) begin
          vals_d[i] = '0;
        end
        bad_d = 1'b0;
      end else if (phase_q != PH_IGNORE) begin
        if (in_if.ch == CH_SEMI) begin
          if (phase_q != PH_BETWEEN) begin
            vals_d  = vals_c;
            bad_d   = bad_c;
            idx_d   = idx_c;
            phase_d = phase_c;
          end
        end else begin
          if (phase_q == PH_BETWEEN) begin
            ph      = PH_LEAD;
            phase_d = PH_LEAD;
            acc_d   = '0;
            neg_d   = 1'b0;
          end
          case (ph)
            PH_LEAD: begin
              if (is_ws(in_if.ch)) begin
                phase_d = PH_LEAD;
              end else if ((in_if.ch == CH_PLUS) || (in_if.ch == CH_MINUS)) begin
                neg_d   = (in_if.ch == CH_MINUS);
                phase_d = PH_SIGN;
              end else if (is_digit(in_if.ch)) begin
                acc_d   = VAL_W'(in_if.ch[3:0]);
                phase_d = PH_DIGITS;
              end else begin
                phase_d = PH_BAD;
              end
            end
            PH_SIGN: begin
              if (is_digit(in_if.ch)) begin
                acc_d   = VAL_W'(in_if.ch[3:0]);
                phase_d = PH_DIGITS;
              end else begin
                phase_d = PH_BAD;
              end
            end
            PH_DIGITS: begin
              if (is_digit(in_if.ch)) begin
                mac   = MAC_W'(acc_q) * MAC_W'(10) + MAC_W'(in_if.ch[3:0]);
                acc_d = (mac > MAC_W'(ACC_SAT)) ? ACC_SAT : mac[VAL_W-1:0];
              end else begin
                phase_d = PH_BAD;
              end
            end
            default: begin
            end
          endcase
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_BETWEEN;
      idx_q       <= '0;
      acc_q       <= '0;
      neg_q       <= 1'b0;
      for (int i = 0; i < FIELD_COUNT; i++) begin
        vals_q[i] <= '0;
      end
      bad_q       <= 1'b0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      idx_q       <= idx_d;
      acc_q       <= acc_d;
      neg_q       <= neg_d;
      vals_q      <= vals_d;
      bad_q       <= bad_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ok_q     <= ok_d;
    year_q   <= year_d;
    month_q  <= month_d;
    day_q    <= day_d;
    hour_q   <= hour_d;
    minute_q <= minute_d;
    temp_q   <= temp_d;
    glc_q    <= glc_d;
  end

  assign out_if.valid           = out_valid_q;
  assign out_if.ok              = ok_q;
  assign out_if.year            = year_q;
  assign out_if.month           = month_q;
  assign out_if.day             = day_q;
  assign out_if.hour            = hour_q;
  assign out_if.minute          = minute_q;
  assign out_if.temperature     = $signed(temp_q);
  assign out_if.good_line_count = glc_q;

  // ignore phase only once all fields are closed
  a_ignore_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_IGNORE) |-> (idx_q == IDX_FULL))
    else $error("ignore phase with open fields");

  a_idx_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    idx_q <= IDX_FULL)
    else $error("field index beyond field count");

  // a line end always leaves a record pending
  a_end_record: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && in_if.line_end) |=> out_valid_q)
    else $error("line end without record");

  // bad records carry zero fields
  a_bad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !ok_q) |-> ((year_q == '0) && (month_q == '0) && (day_q == '0) &&
                                (hour_q == '0) && (minute_q == '0) && (temp_q == '0)))
    else $error("invalid record with nonzero field");

  // good records lie in range
  a_ok_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && ok_q) |-> ((year_q >= 14'd1000) && (year_q <= 14'd9999) &&
                               (month_q >= 4'd1) && (month_q <= 4'd12) &&
                               (day_q >= 5'd1) && (hour_q <= 5'd23) &&
                               (minute_q <= 6'd59) &&
                               ($signed(temp_q) >= -8'sd99) && ($signed(temp_q) <= 8'sd99)))
    else $error("good record out of range");

  // a line end clears the per-line state
  a_line_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && in_if.line_end) |=> ((phase_q == PH_BETWEEN) && (idx_q == '0) && !bad_q))
    else $error("line state not cleared");

endmodule

FILE: tb/tb_dlv_record_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_dlv_record_checker
// Watches both channels of the delimited record validator. Every accepted
// byte request runs through a line parser kept here, every line end queues
// the record it should produce, and every accepted record is compared field
// by field with the oldest queued one.
// ----------------------------------------------------------------------------
module tb_dlv_record_checker
  import dlv_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  dlv_in_if    in_mon,
  dlv_out_if   out_mon,
  output int   fail_count_o,
  output int   pending_o
);

  typedef struct packed {
    logic        ok;
    logic [13:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [7:0]  temperature;
    logic [23:0] count;
  } record_t;

  localparam int FIELD_LO [FIELD_COUNT] = '{1000, 1, 1, 0, 0, -99};
  localparam int FIELD_HI [FIELD_COUNT] = '{9999, 12, 31, 23, 59, 99};
  localparam int MAG_SAT = 10000;
  localparam logic [23:0] COUNT_MAX = '1;

  record_t     record_q [$];
  logic [2:0]  tok_idx;
  phase_e      phase;
  logic [13:0] mag;
  logic        minus;
  logic [13:0] tok_val [FIELD_COUNT];
  logic        line_fault;
  logic [23:0] good_total;
  int          fails = 0;
  int          waiting = 0;

  assign fail_count_o = fails;
  assign pending_o    = waiting;

  function automatic void clear_line();
    tok_idx    = '0;
    phase      = PH_BETWEEN;
    mag        = '0;
    minus      = 1'b0;
    foreach (tok_val[i]) tok_val[i] = '0;
    line_fault = 1'b0;
  endfunction

  function automatic void close_field();
    int v;
    if (tok_idx >= FIELD_COUNT) begin
      phase = PH_IGNORE;
      return;
    end
    if (phase == PH_DIGITS) begin
      v = minus ? -int'(mag) : int'(mag);
      if (v >= FIELD_LO[tok_idx] && v <= FIELD_HI[tok_idx]) begin
        tok_val[tok_idx] = v[13:0];
      end else begin
        line_fault = 1'b1;
      end
    end else begin
      line_fault = 1'b1;
    end
    tok_idx = tok_idx + 3'd1;
    phase   = (tok_idx >= FIELD_COUNT) ? PH_IGNORE : PH_BETWEEN;
  endfunction

  function automatic void parse_byte(input logic [7:0] c);
    int acc;
    if (phase == PH_IGNORE) return;
    if (c == CH_SEMI) begin
      if (phase != PH_BETWEEN) close_field();
      return;
    end
    if (phase == PH_BETWEEN) begin
      phase = PH_LEAD;
      mag   = '0;
      minus = 1'b0;
    end
    case (phase)
      PH_LEAD: begin
        if (c inside {[8'h09:8'h0D], CH_SPACE}) begin
          phase = PH_LEAD;
        end else if (c == CH_PLUS || c == CH_MINUS) begin
          minus = (c == CH_MINUS);
          phase = PH_SIGN;
        end else if (c inside {[CH_ZERO:CH_NINE]}) begin
          mag   = 14'(c - CH_ZERO);
          phase = PH_DIGITS;
        end else begin
          phase = PH_BAD;
        end
      end
      PH_SIGN: begin
        if (c inside {[CH_ZERO:CH_NINE]}) begin
          mag   = 14'(c - CH_ZERO);
          phase = PH_DIGITS;
        end else begin
          phase = PH_BAD;
        end
      end
      PH_DIGITS: begin
        if (c inside {[CH_ZERO:CH_NINE]}) begin
          acc = int'(mag) * 10 + int'(c - CH_ZERO);
          mag = (acc > MAG_SAT) ? 14'(MAG_SAT) : 14'(acc);
        end else begin
          phase = PH_BAD;
        end
      end
      default: begin
      end
    endcase
  endfunction

  function automatic record_t finish_line();
    record_t rec;
    logic    ok;
    if (phase != PH_BETWEEN && phase != PH_IGNORE) close_field();
    ok              = !line_fault && (tok_idx >= FIELD_COUNT);
    rec.ok          = ok;
    rec.year        = ok ? tok_val[0]      : '0;
    rec.month       = ok ? tok_val[1][3:0] : '0;
    rec.day         = ok ? tok_val[2][4:0] : '0;
    rec.hour        = ok ? tok_val[3][4:0] : '0;
    rec.minute      = ok ? tok_val[4][5:0] : '0;
    rec.temperature = ok ? tok_val[5][7:0] : '0;
    rec.count       = good_total;
    if (ok && good_total != COUNT_MAX) good_total = good_total + 24'd1;
    clear_line();
    return rec;
  endfunction

  task automatic check_field(input string name, input logic signed [31:0] exp_v,
                             input logic signed [31:0] act_v);
    if (act_v !== exp_v) begin
      $error("%s mismatch: expected %0d, actual %0d", name, exp_v, act_v);
      fails++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    record_t exp_rec;
    if (!rst_ni) begin
      clear_line();
      good_total = '0;
      record_q.delete();
      waiting = 0;
    end else begin
      if (in_mon.valid === 1'b1 && in_mon.ready === 1'b1) begin
        if (in_mon.line_end) begin
          record_q.push_back(finish_line());
        end else begin
          parse_byte(in_mon.ch);
        end
      end
      if (out_mon.valid === 1'b1 && out_mon.ready === 1'b1) begin
        if (record_q.size() == 0) begin
          $error("record request with no line end waiting");
          fails++;
        end else begin
          exp_rec = record_q.pop_front();
          check_field("ok", exp_rec.ok, out_mon.ok);
          check_field("year", exp_rec.year, out_mon.year);
          check_field("month", exp_rec.month, out_mon.month);
          check_field("day", exp_rec.day, out_mon.day);
          check_field("hour", exp_rec.hour, out_mon.hour);
          check_field("minute", exp_rec.minute, out_mon.minute);
          check_field("temperature", $signed(exp_rec.temperature),
                      $signed(out_mon.temperature));
          check_field("good_line_count", exp_rec.count, out_mon.good_line_count);
        end
      end
      waiting = record_q.size();
    end
  end

endmodule

FILE: tb/tb_delimited_record_validator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_delimited_record_validator
// Feeds the validator with directed lines for the parsing corner cases and
// then with random lines, mostly well formed with random content and some
// damaged or pure noise. Both channels idle at random; once the record side
// holds off long enough to stall the byte side. The checker beside the block
// predicts and compares; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_delimited_record_validator;
  import dlv_pkg::*;

  typedef enum int {
    DMG_NONE,
    DMG_MISSING,
    DMG_GARBAGE,
    DMG_TRAIL_WS,
    DMG_SIGN_ONLY,
    DMG_BLANK
  } damage_e;

  localparam int FIELD_LO [FIELD_COUNT] = '{1000, 1, 1, 0, 0, -99};
  localparam int FIELD_HI [FIELD_COUNT] = '{9999, 12, 31, 23, 59, 99};
  localparam int RANDOM_BYTES = 540;
  localparam int HOLD_CYCLES  = 400;
  localparam int CYCLE_LIMIT  = 500000;
  localparam int DRAIN_CYCLES = 20;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;
  int   fail_count;
  int   pending;
  int   cycles = 0;
  int   sent_bytes = 0;
  bit   steady = 1'b0;
  bit   hold_go = 1'b0;
  bit   hold_active = 1'b0;
  logic [7:0] line_buf [$];

  dlv_in_if  in_ch ();
  dlv_out_if out_ch ();

  delimited_record_validator #(
    .COUNT_WIDTH(24)
  ) u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_if  (in_ch),
    .out_if (out_ch)
  );

  tb_dlv_record_checker u_chk (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_mon       (in_ch),
    .out_mon      (out_ch),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  always begin
    clk_i = 1'b1;
    #2;
    clk_i = 1'b0;
    #2;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("delimited_record_validator verification failed");
      $finish;
    end
  end

  function automatic logic [7:0] pick_blank();
    int k;
    k = $urandom_range(0, 5);
    return (k == 5) ? CH_SPACE : 8'(CH_TAB + k);
  endfunction

  task automatic add_text(input string s);
    for (int i = 0; i < s.len(); i++) line_buf.push_back(s[i]);
  endtask

  // random number for field f, mostly in range, with random blanks, sign and zeros
  task automatic add_field(input int f);
    int v;
    int r;
    int mag;
    r = $urandom_range(0, 99);
    if (r < 65) begin
      v = FIELD_LO[f] + int'($urandom_range(0, FIELD_HI[f] - FIELD_LO[f]));
    end else if (r < 78) begin
      v = r[0] ? FIELD_LO[f] : FIELD_HI[f];
    end else if (r < 88) begin
      v = r[0] ? FIELD_LO[f] - 1 : FIELD_HI[f] + 1;
    end else begin
      v = int'($urandom_range(10000, 99999999)) * (r[0] ? -1 : 1);
    end
    if ($urandom_range(0, 3) == 0) begin
      repeat ($urandom_range(1, 2)) line_buf.push_back(pick_blank());
    end
    if (v < 0) begin
      line_buf.push_back(CH_MINUS);
    end else if ($urandom_range(0, 6) == 0) begin
      line_buf.push_back(CH_PLUS);
    end else if (v == 0 && $urandom_range(0, 3) == 0) begin
      line_buf.push_back(CH_MINUS);
    end
    mag = (v < 0) ? -v : v;
    if ($urandom_range(0, 6) == 0) begin
      repeat ($urandom_range(1, 2)) line_buf.push_back(CH_ZERO);
    end
    add_text($sformatf("%0d", mag));
  endtask

  task automatic push_item(input logic [7:0] c, input logic e);
    int gap;
    int r;
    if (hold_active || steady) begin
      gap = 0;
    end else begin
      r = $urandom_range(0, 99);
      if (r < 55)      gap = 0;
      else if (r < 85) gap = $urandom_range(1, 3);
      else if (r < 97) gap = $urandom_range(4, 10);
      else             gap = $urandom_range(20, 60);
    end
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_ch.valid    <= 1'b1;
    in_ch.ch       <= c;
    in_ch.line_end <= e;
    do @(posedge clk_i); while (in_ch.ready !== 1'b1);
    sent_bytes++;
    @(negedge clk_i);
  endtask

  task automatic send_line();
    foreach (line_buf[i]) push_item(line_buf[i], 1'b0);
    push_item(8'($urandom_range(0, 255)), 1'b1);
    line_buf.delete();
    steady = ($urandom_range(0, 3) == 0);
  endtask

  // record side: random ready with stretches, plus one long hold-off on request
  initial begin
    int r;
    bit hold_done;
    hold_done    = 1'b0;
    out_ch.ready = 1'b0;
    @(posedge rst_ni);
    @(negedge clk_i);
    forever begin
      if (hold_go && !hold_done) begin
        hold_active = 1'b1;
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk_i);
        hold_active = 1'b0;
        hold_done   = 1'b1;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 40) begin
          out_ch.ready <= 1'b1;
          repeat ($urandom_range(5, 40)) @(negedge clk_i);
        end else if (r < 90) begin
          repeat ($urandom_range(5, 30)) begin
            out_ch.ready <= ($urandom_range(0, 3) != 0);
            @(negedge clk_i);
          end
        end else begin
          out_ch.ready <= 1'b0;
          repeat ($urandom_range(10, 60)) @(negedge clk_i);
        end
      end
    end
  end

  initial begin
    int      kind;
    int      r;
    int      start_bytes;
    int      bad_fld;
    damage_e damage;
    in_ch.valid    = 1'b0;
    in_ch.ch       = '0;
    in_ch.line_end = 1'b0;
    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    add_text("2023;6;15;12;30;25");
    send_line();
    add_text("1000;1;1;0;0;-99");
    send_line();
    add_text("9999;12;31;23;59;99");
    send_line();
    add_text("999;13;32;24;60;100");
    send_line();
    // empty line
    send_line();
    // every blank byte, empty tokens, signs
    add_text(";; \t+2000;;;");
    line_buf.push_back(8'h0B);
    add_text("1;");
    line_buf.push_back(8'h0C);
    line_buf.push_back(8'h0D);
    line_buf.push_back(8'h0A);
    add_text("+1;;; 0;-0;+99;");
    send_line();
    add_text("2020;1");
    line_buf.push_back(8'h00);
    add_text(";1;0;0;1");
    send_line();
    add_text("2020;-;1;0;0;1");
    send_line();
    add_text("2020;+ 5;1;0;0;1");
    send_line();
    add_text("2020 ;1;1;0;0;1");
    send_line();
    add_text("10000;1;1;0;0;-100000");
    send_line();
    add_text("0002021;2;3;4;5;-7;tail text;;9x");
    send_line();
    add_text("2021;2;3;4;5;6x");
    send_line();
    add_text("2021;2;3;4;5");
    send_line();
    add_text("2021;  ;3;4;5;6");
    send_line();
    add_text("1999;12;31;23;59;-0");
    send_line();

    // drain, then let the record side hold off while bytes keep coming
    in_ch.valid <= 1'b0;
    @(negedge clk_i);
    wait (pending == 0);
    hold_go = 1'b1;
    wait (hold_active);
    @(negedge clk_i);

    start_bytes = sent_bytes;
    while (sent_bytes - start_bytes < RANDOM_BYTES) begin
      kind = $urandom_range(0, 99);
      if (kind < 12) begin
        repeat ($urandom_range(0, 14)) begin
          r = $urandom_range(0, 9);
          if (r < 3)      line_buf.push_back(CH_SEMI);
          else if (r < 5) line_buf.push_back(8'(CH_ZERO + $urandom_range(0, 9)));
          else            line_buf.push_back(8'($urandom_range(0, 255)));
        end
      end else begin
        damage  = (kind < 40) ? damage_e'($urandom_range(1, 5)) : DMG_NONE;
        bad_fld = $urandom_range(0, 5);
        if ($urandom_range(0, 4) == 0) line_buf.push_back(CH_SEMI);
        for (int f = 0; f < FIELD_COUNT; f++) begin
          if (f == bad_fld && damage == DMG_MISSING) continue;
          if (f == bad_fld && damage == DMG_SIGN_ONLY) begin
            line_buf.push_back($urandom_range(0, 1) ? CH_PLUS : CH_MINUS);
            if ($urandom_range(0, 1)) line_buf.push_back(pick_blank());
          end else if (f == bad_fld && damage == DMG_BLANK) begin
            repeat ($urandom_range(1, 3)) line_buf.push_back(pick_blank());
          end else begin
            add_field(f);
            if (f == bad_fld && damage == DMG_GARBAGE) begin
              line_buf.push_back(8'($urandom_range(0, 255)));
            end
            if (f == bad_fld && damage == DMG_TRAIL_WS) line_buf.push_back(pick_blank());
          end
          if (f < FIELD_COUNT - 1) begin
            line_buf.push_back(CH_SEMI);
            if ($urandom_range(0, 3) == 0) line_buf.push_back(CH_SEMI);
          end
        end
        r = $urandom_range(0, 99);
        if (r < 25) begin
          line_buf.push_back(CH_SEMI);
          add_field($urandom_range(0, 5));
          repeat ($urandom_range(0, 4)) line_buf.push_back(8'($urandom_range(0, 255)));
        end else if (r < 40) begin
          line_buf.push_back(CH_SEMI);
        end
      end
      send_line();
    end

    in_ch.valid <= 1'b0;
    @(negedge clk_i);
    wait (pending == 0);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("delimited_record_validator verification clean");
    end else begin
      $display("delimited_record_validator verification failed");
    end
    $finish;
  end

endmodule
